// ===== design/mred_pkg.sv =====
package mred_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int FRAC_BITS    = 8;
   localparam int MAX_DIM      = 1024;

   localparam int DIM_W   = $clog2(MAX_DIM) + 1;          // 11
   localparam int CNT_W   = 2 * DIM_W;                    // pixel count
   localparam int SQ_W    = 2 * CHANNEL_BITS + 2;         // dr^2+dg^2+db^2
   localparam int RAD_W   = SQ_W + 2 * FRAC_BITS;         // sqrt operand
   localparam int ROOT_W  = RAD_W / 2;                    // Q9.8 distance
   localparam int REM_W   = ROOT_W + 2;                   // sqrt remainder
   localparam int SUM_W   = 37;
   localparam int OUT_W   = 17;
   localparam int STEP_W  = $clog2(SUM_W);
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef enum logic [1:0] {
      REG_REF_WIDTH   = 2'd0,
      REG_REF_HEIGHT  = 2'd1,
      REG_CAND_WIDTH  = 2'd2,
      REG_CAND_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] ref_red;
      logic [CHANNEL_BITS-1:0] ref_green;
      logic [CHANNEL_BITS-1:0] ref_blue;
      logic [CHANNEL_BITS-1:0] cand_red;
      logic [CHANNEL_BITS-1:0] cand_green;
      logic [CHANNEL_BITS-1:0] cand_blue;
      logic                    last_pixel;
   } req_data_type;

   typedef struct packed {
      logic [OUT_W-1:0] mean_distance;
      logic             size_mismatch;
   } rsp_data_type;

   typedef struct packed {
      logic [DIM_W-1:0] ref_width;
      logic [DIM_W-1:0] ref_height;
      logic [DIM_W-1:0] cand_width;
      logic [DIM_W-1:0] cand_height;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic root_step;
      logic accum;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic out_busy;
   } status_type;

endpackage

// ===== design/mean_rgb_euclidean_distance_core.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_data (pixel pair, last_pixel)
// rsp      out        rsp_valid/rsp_stall   rsp_data (mean_distance, size_mismatch)
// csr      in         APB write/read        ref/cand width and height
//
// After a transfer, a pixel pair is squared, then passes through the 17 steps
// of the square-root loop and is accumulated before the next pair is taken.
// The last pair then loads the 37-step divider, runs it and loads the output.
// Reset is synchronous; it clears the running sum and restores sizes to 1.
// A stalled result holds in the output register; new pairs keep flowing
// until the next last pair's result needs that register.
module mean_rgb_euclidean_distance_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mred_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mred_pkg::rsp_data_type        rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mred_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [mred_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [mred_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import mred_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   mred_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mred_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mred_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/mred_csr.sv =====
module mred_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mred_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [mred_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [mred_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output mred_pkg::cfg_type             cfg
);
   import mred_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;
   logic          wr_en;
   logic [DIM_W-1:0] rd_val;

   assign idx   = csr_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_REF_WIDTH:   cfg_in.ref_width   = csr_pwdata[DIM_W-1:0];
            REG_REF_HEIGHT:  cfg_in.ref_height  = csr_pwdata[DIM_W-1:0];
            REG_CAND_WIDTH:  cfg_in.cand_width  = csr_pwdata[DIM_W-1:0];
            REG_CAND_HEIGHT: cfg_in.cand_height = csr_pwdata[DIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_REF_WIDTH:   rd_val = cfg_ff.ref_width;
         REG_REF_HEIGHT:  rd_val = cfg_ff.ref_height;
         REG_CAND_WIDTH:  rd_val = cfg_ff.cand_width;
         REG_CAND_HEIGHT: rd_val = cfg_ff.cand_height;
         default:         rd_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_width   <= DIM_W'(1);
         cfg_ff.ref_height  <= DIM_W'(1);
         cfg_ff.cand_width  <= DIM_W'(1);
         cfg_ff.cand_height <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = CSR_DW'(rd_val);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== design/mred_ctrl.sv =====
module mred_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mred_pkg::status_type status,
   output mred_pkg::cmd_type    cmd
);
   import mred_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              root_end;
   logic              div_end;

   assign root_end = (step_ff == STEP_W'(ROOT_W - 1));
   assign div_end  = (step_ff == STEP_W'(SUM_W - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:   state_in = ST_ROOT;
         ST_ROOT:     if (root_end) state_in = ST_ACCUM;
         ST_ACCUM:    state_in = status.last_pixel ? ST_DIV_LOAD : ST_IDLE;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE:   if (div_end) state_in = ST_RESULT;
         ST_RESULT:   if (!status.out_busy) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // one step counter serves both iterative loops
   always_comb begin
      case (state_ff)
         ST_ROOT, ST_DIVIDE: step_in = step_ff + STEP_W'(1);
         default:            step_in = '0;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SQUARE:   cmd.square    = 1'b1;
         ST_ROOT:     cmd.root_step = 1'b1;
         ST_ACCUM:    cmd.accum     = 1'b1;
         ST_DIV_LOAD: cmd.div_load  = 1'b1;
         ST_DIVIDE:   cmd.div_step  = 1'b1;
         ST_RESULT:   cmd.out_load  = !status.out_busy;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/mred_dp.sv =====
module mred_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mred_pkg::req_data_type req_data,
   input  mred_pkg::cfg_type      cfg,
   input  mred_pkg::cmd_type      cmd,
   output mred_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mred_pkg::rsp_data_type rsp_data
);
   import mred_pkg::*;

   logic [CHANNEL_BITS-1:0] dr_ff, dg_ff, db_ff;
   logic [CHANNEL_BITS-1:0] dr_in, dg_in, db_in;
   logic                    last_ff, last_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SUM_W-1:0]        dvd_ff, dvd_in;
   logic [CNT_W-1:0]        drem_ff, drem_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    mis_ff, mis_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;

   logic [SQ_W-1:0]         sq;
   logic [REM_W+1:0]        rem_sh;
   logic [REM_W-1:0]        trial;
   logic                    root_bit;
   logic [CNT_W:0]          drem_sh;
   logic                    quot_bit;

   function automatic logic [CHANNEL_BITS-1:0] absdiff(
      input logic [CHANNEL_BITS-1:0] a,
      input logic [CHANNEL_BITS-1:0] b
   );
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   assign sq = SQ_W'(dr_ff) * SQ_W'(dr_ff)
             + SQ_W'(dg_ff) * SQ_W'(dg_ff)
             + SQ_W'(db_ff) * SQ_W'(db_ff);

   // digit-by-digit square root, two radicand bits per step
   assign rem_sh   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial    = {root_ff, 2'b01};
   assign root_bit = (rem_sh >= (REM_W+2)'(trial));

   // restoring divide, dividend shifts out as quotient shifts in
   assign drem_sh  = {drem_ff, dvd_ff[SUM_W-1]};
   assign quot_bit = (drem_sh >= (CNT_W+1)'(count_ff));

   assign count_in = CNT_W'(cfg.ref_width) * CNT_W'(cfg.ref_height);

   always_comb begin
      dr_in       = dr_ff;
      dg_in       = dg_ff;
      db_in       = db_ff;
      last_in     = last_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      sum_in      = sum_ff;
      dvd_in      = dvd_ff;
      drem_in     = drem_ff;
      mis_in      = mis_ff;
      zero_in     = zero_ff;
      rsp_data_in = rsp_data_ff;

      if (cmd.load) begin
         dr_in   = absdiff(req_data.ref_red,   req_data.cand_red);
         dg_in   = absdiff(req_data.ref_green, req_data.cand_green);
         db_in   = absdiff(req_data.ref_blue,  req_data.cand_blue);
         last_in = req_data.last_pixel;
      end
      if (cmd.square) begin
         rad_in  = RAD_W'(sq) << (2 * FRAC_BITS);
         rem_in  = '0;
         root_in = '0;
      end
      if (cmd.root_step) begin
         rad_in  = rad_ff << 2;
         rem_in  = root_bit ? REM_W'(rem_sh - (REM_W+2)'(trial)) : REM_W'(rem_sh);
         root_in = {root_ff[ROOT_W-2:0], root_bit};
      end
      if (cmd.accum) begin
         sum_in = sum_ff + SUM_W'(root_ff);
      end
      if (cmd.div_load) begin
         dvd_in  = sum_ff;
         sum_in  = '0;
         drem_in = '0;
         mis_in  = (cfg.ref_width != cfg.cand_width) || (cfg.ref_height != cfg.cand_height);
         zero_in = (count_ff == '0);
      end
      if (cmd.div_step) begin
         drem_in = quot_bit ? CNT_W'(drem_sh - (CNT_W+1)'(count_ff)) : CNT_W'(drem_sh);
         dvd_in  = {dvd_ff[SUM_W-2:0], quot_bit};
      end
      if (cmd.out_load) begin
         if (mis_ff || zero_ff || (dvd_ff > SUM_W'(OUT_MAX))) begin
            rsp_data_in.mean_distance = OUT_MAX;
         end else begin
            rsp_data_in.mean_distance = dvd_ff[OUT_W-1:0];
         end
         rsp_data_in.size_mismatch = mis_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dr_ff       <= dr_in;
      dg_ff       <= dg_in;
      db_ff       <= db_in;
      last_ff     <= last_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      count_ff    <= count_in;
      mis_ff      <= mis_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.last_pixel = last_ff;
   assign status.out_busy   = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

// ===== design/mred_checker.sv =====
module mred_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mred_pkg::rsp_data_type rsp_data
);
   import mred_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_mismatch_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.size_mismatch |-> rsp_data.mean_distance == OUT_MAX)
      else $error("size mismatch without saturated distance");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second pair taken while one is in work");

endmodule

bind mean_rgb_euclidean_distance_core mred_checker u_mred_checker (.*);
